### hdl/ccsx_pkg.sv
// Shared types, constants and the ChaCha quarter-round function for the stream XOR block.
`timescale 1ns / 1ps

package ccsx_pkg;

  // Cipher configuration: 10 double rounds gives standard ChaCha20.
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_COUNT   = 2 * DOUBLE_ROUNDS;
  localparam int RND_W         = $clog2(ROUND_COUNT);

  // Field widths.
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 4;
  localparam int TDATA_W = 72;
  localparam int PAD_W   = TDATA_W - DATA_W - CNT_W;
  localparam int POS_W   = 3;
  localparam int WORD_W  = 32;

  // Configuration port.
  localparam int APB_DATA_W = 64;
  localparam int ADDR_W     = 6;

  // State words 0..3 ("expand 32-byte k").
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6B206574, 32'h79622D32, 32'h3320646E, 32'h61707865
  };

  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_START    = 3'd6
  } ccsx_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } ccsx_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the accepted input word
    logic load;       // load the working state from the initial state
    logic round;      // run one column or diagonal round
    logic diag;       // the round is a diagonal round
    logic final_add;  // add the initial state, advance the block counter
    logic emit;       // write the result word to the output register
  } ccsx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_zero;   // next word starts a new keystream block
    logic out_free;   // output register can take a word this cycle
  } ccsx_sts_t;

  typedef logic [3:0][WORD_W-1:0] qr_t;

  function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // One quarter round on words a, b, c, d held in elements 0..3.
  function automatic qr_t quarter_round(qr_t x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    qr_t r;
    a = x[0];
    b = x[1];
    c = x[2];
    d = x[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

endpackage

### hdl/chacha20_stream_xor.sv
// Top level of the ChaCha20 stream XOR block (20 rounds, 96-bit nonce, 32-bit counter).
// A word that opens a 64-byte block passes the twenty round states, the final add and the emit
// state before it is written to the output register; any other word goes straight to the emit
// state. The emit state waits until the output register is free. One word is in flight at a
// time: a new word is taken only after the last one has been written to the output register.
// Reset (rst, synchronous, active high) restores the register defaults and starts a new message.
`timescale 1ns / 1ps

module chacha20_stream_xor (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream. s_tdata: data_in [63:0], bytes_valid [67:64], zero [71:68].
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ccsx_pkg::TDATA_W-1:0]    s_tdata,
  input  logic                            s_tlast,
  // Output stream. m_tdata: data_out [63:0], bytes_out [67:64], zero [71:68].
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ccsx_pkg::TDATA_W-1:0]    m_tdata,
  output logic                            m_tlast,
  // Configuration port; register i sits at byte address 8*i.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccsx_pkg::ADDR_W-1:0]     paddr,
  input  logic [ccsx_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ccsx_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ccsx_pkg::*;

  // The controller owns sequencing: it takes one word, runs the twenty rounds when the
  // word starts a new keystream block, and hands the word to the output register. The
  // datapath holds the configuration registers, the sixteen-word working state (which
  // also serves as the keystream store once the final add is done), the block counter
  // and the output register, so a finished word can wait there while the next is taken.
  ccsx_cmd_t cmd;
  ccsx_sts_t sts;

  // Registers are always ready; writes complete in the access phase.
  assign pready = 1'b1;

  ccsx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccsx_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

  // Only one word is processed at a time.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is still in process");

  // The final add always follows the last round.
  a_final_after_round: assert property (@(posedge clk) disable iff (rst)
    cmd.final_add |-> $past(cmd.round))
    else $error("final add without preceding round");

  // An emitted word shows up in the output register.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted word not presented on output");

  // Once a word marked last is out, the next word starts a new block.
  a_last_resets_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> sts.pos_zero)
    else $error("word position not reset after last word");

endmodule

### hdl/ccsx_ctrl.sv
// Controller state machine: sequences input capture, the round loop and result output.
`timescale 1ns / 1ps

module ccsx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ccsx_pkg::ccsx_sts_t sts,
  output ccsx_pkg::ccsx_cmd_t cmd
);
  import ccsx_pkg::*;

  ccsx_state_t      state;
  ccsx_state_t      state_next;
  logic [RND_W-1:0] rnd_cnt;
  logic [RND_W-1:0] rnd_cnt_next;
  logic             accept;

  assign accept = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rnd_cnt <= '0;
    end else begin
      state   <= state_next;
      rnd_cnt <= rnd_cnt_next;
    end
  end

  // Next state.
  always_comb begin
    state_next   = state;
    rnd_cnt_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = sts.pos_zero ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        if (rnd_cnt == RND_W'(ROUND_COUNT - 1)) begin
          state_next = ST_FINAL;
        end else begin
          rnd_cnt_next = rnd_cnt + 1'b1;
        end
      end
      ST_FINAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.capture   = accept;
    cmd.load      = accept && sts.pos_zero;
    cmd.diag      = rnd_cnt[0];
    case (state)
      ST_IDLE:  s_tready      = 1'b1;
      ST_ROUND: cmd.round     = 1'b1;
      ST_FINAL: cmd.final_add = 1'b1;
      ST_EMIT:  cmd.emit      = sts.out_free;
      default:  s_tready      = 1'b0;
    endcase
  end

endmodule

### hdl/ccsx_dp.sv
// Datapath: configuration registers, ChaCha round unit, keystream state, XOR and output register.
`timescale 1ns / 1ps

module ccsx_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  ccsx_pkg::ccsx_cmd_t             cmd,
  output ccsx_pkg::ccsx_sts_t             sts,
  input  logic [ccsx_pkg::TDATA_W-1:0]    s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ccsx_pkg::TDATA_W-1:0]    m_tdata,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccsx_pkg::ADDR_W-1:0]     paddr,
  input  logic [ccsx_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ccsx_pkg::APB_DATA_W-1:0] prdata
);
  import ccsx_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] key_reg [4];
  logic [DATA_W-1:0] nonce_lo;
  logic [WORD_W-1:0] nonce_hi;
  logic [WORD_W-1:0] start_counter;

  // Message state.
  logic [WORD_W-1:0] block_counter;
  logic [POS_W-1:0]  position;
  logic              in_message;

  // Captured input word.
  logic [DATA_W-1:0] in_data;
  logic [CNT_W-1:0]  in_count;
  logic              in_last;

  // Working state; after the final add it holds the block keystream.
  logic [WORD_W-1:0] work [16];
  logic [WORD_W-1:0] init_w [16];
  logic [WORD_W-1:0] col_res [16];
  logic [WORD_W-1:0] diag_res [16];

  // Output register.
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;

  logic              cfg_wr;
  ccsx_reg_t         cfg_reg;
  logic [DATA_W-1:0] keystream;
  logic [DATA_W-1:0] result;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = ccsx_reg_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        key_reg[k] <= '0;
      end
      nonce_lo      <= '0;
      nonce_hi      <= '0;
      start_counter <= WORD_W'(1);
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_KEY0:     key_reg[0]    <= pwdata;
        REG_KEY1:     key_reg[1]    <= pwdata;
        REG_KEY2:     key_reg[2]    <= pwdata;
        REG_KEY3:     key_reg[3]    <= pwdata;
        REG_NONCE_LO: nonce_lo      <= pwdata;
        REG_NONCE_HI: nonce_hi      <= pwdata[WORD_W-1:0];
        REG_START:    start_counter <= pwdata[WORD_W-1:0];
        default:      nonce_hi      <= nonce_hi;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_KEY0:     prdata = key_reg[0];
      REG_KEY1:     prdata = key_reg[1];
      REG_KEY2:     prdata = key_reg[2];
      REG_KEY3:     prdata = key_reg[3];
      REG_NONCE_LO: prdata = nonce_lo;
      REG_NONCE_HI: prdata = {{(APB_DATA_W - WORD_W){1'b0}}, nonce_hi};
      REG_START:    prdata = {{(APB_DATA_W - WORD_W){1'b0}}, start_counter};
      default:      prdata = '0;
    endcase
  end

  // Initial block state.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      init_w[k]         = SIGMA[k];
      init_w[4 + 2 * k] = key_reg[k][WORD_W-1:0];
      init_w[5 + 2 * k] = key_reg[k][DATA_W-1:WORD_W];
    end
    init_w[12] = block_counter;
    init_w[13] = nonce_lo[WORD_W-1:0];
    init_w[14] = nonce_lo[DATA_W-1:WORD_W];
    init_w[15] = nonce_hi;
  end

  // Four quarter-round units, shared by column and diagonal rounds.
  for (genvar c = 0; c < 4; c++) begin : g_qr
    localparam int D0 = c;
    localparam int D1 = 4 + ((c + 1) % 4);
    localparam int D2 = 8 + ((c + 2) % 4);
    localparam int D3 = 12 + ((c + 3) % 4);
    qr_t qin;
    qr_t qout;
    assign qin = cmd.diag ? {work[D3], work[D2], work[D1], work[D0]}
                          : {work[c + 12], work[c + 8], work[c + 4], work[c]};
    assign qout = quarter_round(qin);
    assign col_res[c]      = qout[0];
    assign col_res[c + 4]  = qout[1];
    assign col_res[c + 8]  = qout[2];
    assign col_res[c + 12] = qout[3];
    assign diag_res[D0]    = qout[0];
    assign diag_res[D1]    = qout[1];
    assign diag_res[D2]    = qout[2];
    assign diag_res[D3]    = qout[3];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (cmd.load) begin
        work[i] <= init_w[i];
      end else if (cmd.round) begin
        work[i] <= cmd.diag ? diag_res[i] : col_res[i];
      end else if (cmd.final_add) begin
        work[i] <= work[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_data  <= s_tdata[DATA_W-1:0];
      in_count <= s_tdata[DATA_W +: CNT_W];
      in_last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= WORD_W'(1);
      position      <= '0;
      in_message    <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_reg == REG_START) && !in_message) begin
        block_counter <= pwdata[WORD_W-1:0];
      end else if (cmd.final_add) begin
        block_counter <= block_counter + 1'b1;
      end else if (cmd.emit && in_last) begin
        block_counter <= start_counter;
      end
      if (cmd.emit) begin
        position   <= in_last ? '0 : position + 1'b1;
        in_message <= !in_last;
      end
    end
  end

  assign keystream = {work[{position, 1'b1}], work[{position, 1'b0}]};

  // Bytes at or past the valid count are cleared.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      result[8 * i +: 8] = (in_count > CNT_W'(i)) ? (in_data[8 * i +: 8] ^ keystream[8 * i +: 8])
                                                   : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data  <= result;
      out_count <= in_count;
      out_last  <= in_last;
    end
  end

  assign sts.pos_zero = (position == '0);
  assign sts.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_count, out_data};
  assign m_tlast  = out_last;

endmodule

### test/tb_top.sv
// Self-checking testbench for the ChaCha20 stream XOR block with its own keystream predictor.
`timescale 1ns / 1ps

module tb_top;

  import ccsx_pkg::*;

  // Register index that the block does not decode; writes to it must be ignored.
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  // Words 0..3 of the ChaCha state, "expand 32-byte k" in little-endian words.
  localparam logic [31:0] EXPAND_0 = 32'h6170_7865;
  localparam logic [31:0] EXPAND_1 = 32'h3320_646E;
  localparam logic [31:0] EXPAND_2 = 32'h7962_2D32;
  localparam logic [31:0] EXPAND_3 = 32'h6B20_6574;

  // One word on either stream, kept as 4-state values so that X on an output is caught.
  typedef struct packed {
    logic        last;
    logic [3:0]  pad;
    logic [3:0]  cnt;
    logic [63:0] data;
  } word_t;

  // Keystream predictor and the queue of output words it expects, oldest first.
  class keystream_scoreboard;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] start_ctr;
    logic [31:0] block_ctr;
    logic [2:0]  word_pos;
    logic        in_msg;
    logic [63:0] keystream [8];
    logic [31:0] mix [16];
    word_t       expected_words [$];
    int          fails;

    function new();
      for (int k = 0; k < 4; k++) key_reg[k] = '0;
      nonce_lo  = '0;
      nonce_hi  = '0;
      start_ctr = 32'd1;
      block_ctr = 32'd1;
      word_pos  = '0;
      in_msg    = 1'b0;
      fails     = 0;
      for (int k = 0; k < 8; k++) keystream[k] = '0;
    endfunction

    function logic [31:0] rot32(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void mix_quarter(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 7);
    endfunction

    // Runs the block function on the current counter and refills the keystream.
    function void next_block();
      logic [31:0] init_w [16];
      init_w[0] = EXPAND_0;
      init_w[1] = EXPAND_1;
      init_w[2] = EXPAND_2;
      init_w[3] = EXPAND_3;
      for (int k = 0; k < 4; k++) begin
        init_w[4 + 2 * k] = key_reg[k][31:0];
        init_w[5 + 2 * k] = key_reg[k][63:32];
      end
      init_w[12] = block_ctr;
      init_w[13] = nonce_lo[31:0];
      init_w[14] = nonce_lo[63:32];
      init_w[15] = nonce_hi;
      mix = init_w;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        mix_quarter(0, 4, 8, 12);
        mix_quarter(1, 5, 9, 13);
        mix_quarter(2, 6, 10, 14);
        mix_quarter(3, 7, 11, 15);
        mix_quarter(0, 5, 10, 15);
        mix_quarter(1, 6, 11, 12);
        mix_quarter(2, 7, 8, 13);
        mix_quarter(3, 4, 9, 14);
      end
      for (int k = 0; k < 8; k++)
        keystream[k] = {mix[2 * k + 1] + init_w[2 * k + 1], mix[2 * k] + init_w[2 * k]};
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[idx[1:0]] = v;
        REG_NONCE_LO: nonce_lo = v;
        REG_NONCE_HI: nonce_hi = v[31:0];
        REG_START: begin
          start_ctr = v[31:0];
          // The running counter only reloads between messages.
          if (!in_msg) block_ctr = v[31:0];
        end
        default: ;
      endcase
    endfunction

    function logic [63:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: return key_reg[idx[1:0]];
        REG_NONCE_LO: return nonce_lo;
        REG_NONCE_HI: return {32'd0, nonce_hi};
        REG_START:    return {32'd0, start_ctr};
        default:      return '0;
      endcase
    endfunction

    function void compare_reg(logic [2:0] idx, logic [63:0] got);
      if (got !== reg_value(idx)) begin
        fails++;
        if (fails <= 10)
          $display("register %0d read mismatch: expected %h, got %h", idx, reg_value(idx), got);
      end
    endfunction

    // Called for every input word the block accepts.
    function void note_word(word_t w);
      word_t       exp;
      int          n;
      logic [63:0] mask;
      if (word_pos == 3'd0) begin
        next_block();
        block_ctr = block_ctr + 32'd1;
      end
      n    = (w.cnt > 4'd8) ? 8 : int'(w.cnt);
      mask = (n >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * n)) - 64'd1);
      exp.data = (w.data ^ keystream[word_pos]) & mask;
      exp.cnt  = w.cnt;
      exp.pad  = '0;
      exp.last = w.last;
      expected_words.push_back(exp);
      if (w.last) begin
        word_pos  = '0;
        block_ctr = start_ctr;
        in_msg    = 1'b0;
      end else begin
        word_pos = word_pos + 3'd1;
        in_msg   = 1'b1;
      end
    endfunction

    // Called for every output word the block hands over.
    function void check_word(word_t got);
      word_t exp;
      if (expected_words.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected output word: data %h cnt %0d last %0d",
                   got.data, got.cnt, got.last);
        return;
      end
      exp = expected_words.pop_front();
      if (got.data !== exp.data || got.cnt !== exp.cnt || got.last !== exp.last ||
          got.pad !== exp.pad) begin
        fails++;
        if (fails <= 10)
          $display("output mismatch: expected data %h cnt %0d last %0d pad %h, got %h %0d %0d %h",
                   exp.data, exp.cnt, exp.last, exp.pad, got.data, got.cnt, got.last, got.pad);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  keystream_scoreboard board;

  // Idle percentages of the two stream sides, changed between test stages.
  int tx_idle_pct = 27;
  int rx_idle_pct = 60;
  // A request for one long receiver hold-off, and the cycles of it still left.
  bit hold_req  = 1'b0;
  int hold_left = 0;

  chacha20_stream_xor i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // Generous ceiling on the whole run; a correct run ends far earlier.
  initial begin
    #2_000_000;
    $display("[chacha20_stream_xor] ERROR");
    $finish;
  end

  // Receiver: checks each word handed over, then decides tready for the next cycle.
  // A hold-off request keeps tready low for a long stretch so the block backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        board.check_word('{last: m_tlast, pad: m_tdata[71:68], cnt: m_tdata[67:64],
                           data: m_tdata[63:0]});
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Setup and access cycle of one write; psel stays high so accesses can run back to back.
  task automatic apb_write(logic [2:0] idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, v);
  endtask

  task automatic check_reg(logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.compare_reg(idx, prdata);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads one full key, nonce and counter setting and reads each register back.
  // Stage 0 is all zeros, stage 1 all ones, stage 2 the sample key of the standard.
  task automatic program_setting(int stage);
    logic [63:0] val [6];
    logic [31:0] ctr;
    case (stage)
      0: begin
        for (int k = 0; k < 6; k++) val[k] = '0;
        ctr = '0;
      end
      1: begin
        for (int k = 0; k < 6; k++) val[k] = '1;
        ctr = 32'hFFFF_FFFF;
      end
      2: begin
        val[0] = 64'h0706_0504_0302_0100;
        val[1] = 64'h0F0E_0D0C_0B0A_0908;
        val[2] = 64'h1716_1514_1312_1110;
        val[3] = 64'h1F1E_1D1C_1B1A_1918;
        val[4] = 64'h4A00_0000_0000_0000;
        val[5] = '0;
        ctr    = 32'd1;
      end
      default: begin
        for (int k = 0; k < 6; k++) val[k] = {$urandom, $urandom};
        ctr = (stage == 5) ? 32'hFFFF_FFFE : $urandom;
      end
    endcase
    apb_write(REG_KEY0, val[0]);
    apb_write(REG_KEY1, val[1]);
    apb_write(REG_KEY2, val[2]);
    apb_write(REG_KEY3, val[3]);
    apb_write(REG_NONCE_LO, val[4]);
    apb_write(REG_NONCE_HI, val[5]);
    apb_write(REG_START, {$urandom, ctr});
    if (stage == 2) apb_write(REG_UNMAPPED, {$urandom, $urandom});
    for (int r = REG_KEY0; r <= REG_START; r++) check_reg(r[2:0]);
    apb_release();
  endtask

  // Offers one word, with random idle cycles ahead of it, and waits for the handshake.
  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, cnt, data};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.note_word('{last: last, pad: 4'b0000, cnt: cnt, data: data});
  endtask

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random messages, mostly well formed: full words and a short final word.
  // About one word in twenty gets an arbitrary byte count, zero and above eight included.
  // With cut set the stage ends inside a message, so the next setting lands mid-message.
  task automatic run_messages(int quota, bit cut);
    int          sent;
    int          len;
    logic [3:0]  cnt;
    logic        last;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        last = (i == len - 1);
        cnt  = last ? 4'($urandom_range(1, 8)) : 4'd8;
        if ($urandom_range(0, 19) == 0) cnt = 4'($urandom_range(0, 15));
        send_word(pick_data(), cnt, last);
        sent++;
      end
    end
    if (cut) send_word(pick_data(), 4'd8, 1'b0);
  endtask

  task automatic wait_drained();
    while (board.expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values of all registers.
    for (int r = REG_KEY0; r <= REG_START; r++) check_reg(r[2:0]);
    apb_release();

    // Directed words under the reset setting. A nine-word message crosses a block
    // boundary with all-zero and all-ones data, then a one-byte message, then a
    // message with a short word that is not last, a zero count and counts above eight, the
    // last of these on its final word, and finally a two-word message ending in a short word.
    send_word('0, 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b0);
    send_word(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
    for (int i = 0; i < 5; i++) send_word(pick_data(), 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b1);
    send_word('1, 4'd1, 1'b1);
    send_word('1, 4'd5, 1'b0);
    send_word('1, 4'd0, 1'b0);
    send_word('1, 4'd15, 1'b0);
    send_word('1, 4'd9, 1'b1);
    send_word(pick_data(), 4'd8, 1'b0);
    send_word('1, 4'd7, 1'b1);
    s_tvalid <= 1'b0;

    // Eight stages, each under a new setting written while the block is idle. The idle
    // pattern moves from a slow receiver to a slow sender to no idling at all.
    for (int st = 0; st < 8; st++) begin
      wait_drained();
      program_setting(st);
      case (st * 3 / 8)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 60;
        end
        1: begin
          tx_idle_pct = 60;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (st == 2) hold_req = 1'b1;
      run_messages(60, st % 2 == 1);
      s_tvalid <= 1'b0;
    end

    // Give the block time to show any stray word after the last expected one.
    wait_drained();
    repeat (40) @(posedge clk);
    if (board.expected_words.size() != 0) begin
      board.fails++;
      $display("%0d expected words never came out", board.expected_words.size());
    end
    if (board.fails == 0) begin
      $display("[chacha20_stream_xor] OK");
    end else begin
      $display("[chacha20_stream_xor] ERROR");
    end
    $finish;
  end

endmodule
